FILE: src/pfe_pkg.sv
// ----------------------------------------------------------------------------
// Playfair encipher package
// Shared types, codes and constants for the Playfair digraph encipher block.
// ----------------------------------------------------------------------------
package pfe_pkg;

	// Letter indexes (A = 0) and ASCII codes.
	localparam logic [4:0] LETTER_I     = 5'd8;
	localparam logic [4:0] LETTER_J     = 5'd9;
	localparam logic [4:0] LETTER_X     = 5'd23;
	localparam logic [4:0] LETTER_LAST  = 5'd25;
	localparam logic [4:0] CELL_COUNT   = 5'd25;
	localparam logic [2:0] SIDE_LAST    = 3'd4;
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
	localparam logic [7:0] ASCII_CASE    = 8'h20;

	// Word kinds on the input channel.
	localparam logic KIND_KEY  = 1'b0;
	localparam logic KIND_TEXT = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_POS,
		ST_CELL,
		ST_EMIT1,
		ST_EMIT2
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic key_load;
		logic text_load;
		logic walk_step;
		logic walk_end;
		logic pos_rd;
		logic cell_rd;
		logic second;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic square_ready;
		logic pair_go;
		logic walk_last;
	} status_t;

endpackage

FILE: src/pfe_ctrl.sv
// ----------------------------------------------------------------------------
// Playfair encipher controller
// Sequences key loading, the square completion walk, the two lookups of a
// letter pair and the delivery of its two cipher words.
// ----------------------------------------------------------------------------
module pfe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             kind,
	input  logic             is_last,
	output logic             out_valid,
	input  logic             out_stall,
	input  pfe_pkg::status_t status,
	output pfe_pkg::cmd_t    cmd
);

	pfe_pkg::state_t state_q;
	pfe_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			pfe_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (kind == pfe_pkg::KIND_KEY) begin
						cmd.key_load = 1'b1;
						if (is_last) begin
							state_d = pfe_pkg::ST_WALK;
						end
					end else if (status.square_ready) begin
						cmd.text_load = 1'b1;
						if (status.pair_go) begin
							state_d = pfe_pkg::ST_POS;
						end
					end
				end
			end
			pfe_pkg::ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (status.walk_last) begin
					cmd.walk_end = 1'b1;
					state_d      = pfe_pkg::ST_IDLE;
				end
			end
			pfe_pkg::ST_POS: begin
				cmd.pos_rd = 1'b1;
				state_d    = pfe_pkg::ST_CELL;
			end
			pfe_pkg::ST_CELL: begin
				cmd.cell_rd = 1'b1;
				state_d     = pfe_pkg::ST_EMIT1;
			end
			pfe_pkg::ST_EMIT1: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = pfe_pkg::ST_EMIT2;
				end
			end
			pfe_pkg::ST_EMIT2: begin
				out_valid  = 1'b1;
				cmd.second = 1'b1;
				if (!out_stall) begin
					state_d = pfe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfe_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: src/pfe_dp.sv
// ----------------------------------------------------------------------------
// Playfair encipher datapath
// Holds the key square and letter position memories, the placement logic,
// the open pair and the lookup registers of the pair being enciphered.
// ----------------------------------------------------------------------------
module pfe_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       char_code,
	input  logic             is_last,
	input  pfe_pkg::cmd_t    cmd,
	output pfe_pkg::status_t status,
	output logic [7:0]       cipher_char,
	output logic             pair_last,
	output logic             message_end
);

	// Memories: cell -> letter, letter -> {row, col}.
	logic [4:0] sq_mem  [25];
	logic [5:0] pos_mem [26];

	logic [25:0] used_q;
	logic [4:0]  fill_q;
	logic        ready_q;
	logic [4:0]  pend_q;
	logic        pend_valid_q;
	logic [4:0]  walk_q;

	logic [4:0]  pair_a_q;
	logic [4:0]  pair_b_q;
	logic        end_q;
	logic [5:0]  pos_a_q;
	logic [5:0]  pos_b_q;
	logic [4:0]  let_a_q;
	logic [4:0]  let_b_q;

	logic        letter_ok;
	logic [4:0]  letter;
	logic        restart;
	logic [25:0] used_eff;
	logic [4:0]  fill_eff;
	logic        plc_en;
	logic [4:0]  plc_letter;
	logic        do_place;
	logic [5:0]  plc_pos;
	logic        pair_go;
	logic [4:0]  addr_a;
	logic [4:0]  addr_b;

	// Folds an 8-bit code to a letter index: case is ignored and J reads as I.
	function automatic logic [5:0] letter_of(input logic [7:0] code);
		logic [7:0] up;
		logic [4:0] idx;
		logic       ok;
		up  = code;
		idx = '0;
		ok  = 1'b0;
		if (code >= pfe_pkg::ASCII_LOWER_A && code <= pfe_pkg::ASCII_LOWER_Z) begin
			up = code - pfe_pkg::ASCII_CASE;
		end
		if (up >= pfe_pkg::ASCII_UPPER_A && up <= pfe_pkg::ASCII_UPPER_Z) begin
			ok  = 1'b1;
			idx = 5'(up - pfe_pkg::ASCII_UPPER_A);
			if (idx == pfe_pkg::LETTER_J) begin
				idx = pfe_pkg::LETTER_I;
			end
		end
		return {ok, idx};
	endfunction

	// Row and column of a cell number, row in the upper three bits.
	function automatic logic [5:0] pos_of(input logic [4:0] cell_num);
		logic [2:0] row;
		logic [4:0] base;
		if (cell_num >= 5'd20) begin
			row  = 3'd4;
			base = 5'd20;
		end else if (cell_num >= 5'd15) begin
			row  = 3'd3;
			base = 5'd15;
		end else if (cell_num >= 5'd10) begin
			row  = 3'd2;
			base = 5'd10;
		end else if (cell_num >= 5'd5) begin
			row  = 3'd1;
			base = 5'd5;
		end else begin
			row  = 3'd0;
			base = 5'd0;
		end
		return {row, 3'(cell_num - base)};
	endfunction

	// Cell number of a row and column.
	function automatic logic [4:0] cell_of(input logic [2:0] row, input logic [2:0] col);
		return 5'({row, 2'b00}) + 5'(row) + 5'(col);
	endfunction

	// Step one row or column on, wrapping around the square.
	function automatic logic [2:0] wrap_inc(input logic [2:0] v);
		return (v == pfe_pkg::SIDE_LAST) ? 3'd0 : v + 3'd1;
	endfunction

	assign {letter_ok, letter} = letter_of(char_code);

	// Placement: a key byte after a finished square starts a new key.
	assign restart    = cmd.key_load && ready_q;
	assign used_eff   = restart ? '0 : used_q;
	assign fill_eff   = restart ? '0 : fill_q;
	assign plc_en     = (cmd.key_load && letter_ok)
	                    || (cmd.walk_step && walk_q != pfe_pkg::LETTER_J);
	assign plc_letter = cmd.walk_step ? walk_q : letter;
	assign do_place   = plc_en && (fill_eff < pfe_pkg::CELL_COUNT)
	                    && !used_eff[plc_letter];
	assign plc_pos    = pos_of(fill_eff);

	// A pair closes on a second letter, or on the last byte with a letter open.
	assign pair_go = pend_valid_q ? (letter_ok || is_last) : (letter_ok && is_last);

	assign status.square_ready = ready_q;
	assign status.pair_go      = pair_go;
	assign status.walk_last    = (walk_q == pfe_pkg::LETTER_LAST);

	// Memory writes.
	always_ff @(posedge clk) begin
		if (do_place) begin
			sq_mem[fill_eff]    <= plc_letter;
			pos_mem[plc_letter] <= plc_pos;
		end
	end

	// Square bookkeeping and completion walk counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			fill_q  <= '0;
			ready_q <= 1'b0;
			walk_q  <= '0;
		end else begin
			if (do_place) begin
				used_q <= used_eff | (26'd1 << plc_letter);
				fill_q <= fill_eff + 5'd1;
			end else if (restart) begin
				used_q <= '0;
				fill_q <= '0;
			end
			if (cmd.key_load) begin
				ready_q <= 1'b0;
				walk_q  <= '0;
			end else if (cmd.walk_step) begin
				walk_q <= walk_q + 5'd1;
				if (cmd.walk_end) begin
					ready_q <= 1'b1;
				end
			end
		end
	end

	// Open pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.key_load) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.text_load) begin
			if (pair_go) begin
				pend_valid_q <= 1'b0;
			end else if (letter_ok) begin
				pend_q       <= letter;
				pend_valid_q <= 1'b1;
			end
		end
	end

	// Pair capture; the second letter is padded with X where none follows.
	always_ff @(posedge clk) begin
		if (cmd.text_load) begin
			pair_a_q <= pend_valid_q ? pend_q : letter;
			pair_b_q <= (pend_valid_q && letter_ok) ? letter : pfe_pkg::LETTER_X;
			end_q    <= is_last;
		end
	end

	// First lookup: position of each letter.
	always_ff @(posedge clk) begin
		if (cmd.pos_rd) begin
			pos_a_q <= pos_mem[pair_a_q];
			pos_b_q <= pos_mem[pair_b_q];
		end
	end

	// Playfair rules: same row, same column, otherwise rectangle.
	always_comb begin
		if (pos_a_q[5:3] == pos_b_q[5:3]) begin
			addr_a = cell_of(pos_a_q[5:3], wrap_inc(pos_a_q[2:0]));
			addr_b = cell_of(pos_a_q[5:3], wrap_inc(pos_b_q[2:0]));
		end else if (pos_a_q[2:0] == pos_b_q[2:0]) begin
			addr_a = cell_of(wrap_inc(pos_a_q[5:3]), pos_a_q[2:0]);
			addr_b = cell_of(wrap_inc(pos_b_q[5:3]), pos_a_q[2:0]);
		end else begin
			addr_a = cell_of(pos_a_q[5:3], pos_b_q[2:0]);
			addr_b = cell_of(pos_b_q[5:3], pos_a_q[2:0]);
		end
	end

	// Second lookup: cipher letters from the square.
	always_ff @(posedge clk) begin
		if (cmd.cell_rd) begin
			let_a_q <= sq_mem[addr_a];
			let_b_q <= sq_mem[addr_b];
		end
	end

	// Output word.
	assign cipher_char = pfe_pkg::ASCII_UPPER_A
	                     + {3'b000, (cmd.second ? let_b_q : let_a_q)};
	assign pair_last   = cmd.second;
	assign message_end = end_q;

endmodule

FILE: src/playfair_digraph_encipher.sv
// Sequence: a key byte is accepted in ST_IDLE; the last key byte starts a walk
// (ST_WALK) that fills the rest of the square. A text byte that closes a pair
// goes through the registered position lookup (ST_POS) and cell lookup
// (ST_CELL); its first cipher word is shown in ST_EMIT1 and the second in
// ST_EMIT2. No new byte is taken until both words of the pair are accepted.
// Reset clears all control state; the square is unusable until a key ends.
// ----------------------------------------------------------------------------
// Playfair digraph encipher
// Builds a 5x5 Playfair square from key words and enciphers text words in
// letter pairs, one cipher letter per output word.
// ----------------------------------------------------------------------------
module playfair_digraph_encipher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] char_code,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] cipher_char,
	output logic       pair_last,
	output logic       message_end
);

	pfe_pkg::cmd_t    cmd;
	pfe_pkg::status_t status;

	// Controller.
	pfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath.
	pfe_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_code   (char_code),
		.is_last     (is_last),
		.cmd         (cmd),
		.status      (status),
		.cipher_char (cipher_char),
		.pair_last   (pair_last),
		.message_end (message_end)
	);

endmodule
